### rtl/assert_macros.svh
// assertion macros shared by the rank compression block
// relies on clk and rst_n being visible where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCS_ASSERT(lbl, prop, msg)
`define RCS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/rcs_pkg.sv
// shared types, widths and sequencer codes for rank_compress_sort_core
// no dependencies
package rcs_pkg;
  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 6;
  localparam int CNT_W         = 7;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [ST_W-1:0] ST_INS   = 3'd1;
  localparam logic [ST_W-1:0] ST_PLACE = 3'd2;
  localparam logic [ST_W-1:0] ST_RD    = 3'd3;
  localparam logic [ST_W-1:0] ST_LD    = 3'd4;
  localparam logic [ST_W-1:0] ST_SADR  = 3'd5;
  localparam logic [ST_W-1:0] ST_SCMP  = 3'd6;
  localparam logic [ST_W-1:0] ST_WAIT  = 3'd7;
endpackage

### rtl/rank_compress_sort_core.sv
// top level of the rank compression block: load sequencer, insertion walk,
// binary search and result register; depends on rcs_pkg, rcs_ram, assert_macros.svh
//
// usage
// - input channel (in_value, in_last) loads one signed element per transfer;
//   in_last closes the set; elements beyond MAX_ITEMS are discarded and flagged
// - each load inserts the element into a sorted memory, walking one entry per
//   cycle down from the top through the single read port of the sorted memory
// - after the closing transfer one result per held element comes out in
//   position order: rank tag, sorted value, sorted tag, overflow flag and a
//   done marker on the final one
// - each result reads its element and sorted entry, then runs two binary searches
//   of up to 7 probes, each probe a memory read then a compare
// - in_ready is high only while the sequencer is idle; no load is taken while
//   results are still being produced
// - a stalled receiver simply holds the result register; the sequencer waits
// - reset clears the count, the overflow flag and the sequencer; memory
//   contents stay undefined and are never used before being written
module rank_compress_sort_core #(
  parameter int MAX_ITEMS = rcs_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rcs_pkg::data_t in_value,
  input  logic           in_last,
  output logic           out_valid,
  input  logic           out_ready,
  output rcs_pkg::addr_t out_position,
  output rcs_pkg::addr_t out_rank,
  output rcs_pkg::data_t out_sorted_value,
  output rcs_pkg::addr_t out_sorted_rank,
  output logic           out_dropped,
  output logic           out_done_res
);
  import rcs_pkg::*;
`include "assert_macros.svh"

  localparam cnt_t MAX_CNT = CNT_W'(MAX_ITEMS);

  // control state
  logic [ST_W-1:0] state_r;
  cnt_t            count_r;
  logic            ovf_r;
  logic            last_r;
  addr_t           j_r;
  addr_t           k_r;
  logic            which_r;

  // payload
  data_t            val_r;
  data_t            target_r;
  data_t            sval_r;
  logic signed [7:0] lo_r;
  logic signed [7:0] hi_r;
  addr_t            mid_r;
  addr_t            rank_r;
  addr_t            srank_r;

  // memory ports
  logic  s_we;
  addr_t s_waddr;
  data_t s_wdata;
  addr_t s_raddr;
  data_t s_rdata;
  logic  e_we;
  data_t e_rdata;

  logic              in_xfer;
  logic              out_xfer;
  logic              room;
  logic signed [7:0] mid_sum;
  addr_t             mid_c;
  logic              probe_ok;
  logic              shift_c;
  logic signed [7:0] hi_init;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_WAIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;
  assign room      = (count_r < MAX_CNT);
  assign mid_sum   = lo_r + hi_r;
  assign mid_c     = mid_sum[6:1];
  assign probe_ok  = (lo_r <= hi_r);
  assign shift_c   = (val_r < s_rdata);
  assign hi_init   = $signed({1'b0, count_r}) - 8'sd1;

  assign out_position     = k_r;
  assign out_rank         = rank_r;
  assign out_sorted_value = sval_r;
  assign out_sorted_rank  = srank_r;
  assign out_dropped      = ovf_r;
  assign out_done_res     = ({1'b0, k_r} == count_r - 7'd1);

  // element store written in arrival order
  assign e_we = in_xfer && room;

  // sorted store: shift entries up during the walk, then drop the value in; also the read address per state
  always_comb begin
    s_we    = 1'b0;
    s_waddr = j_r;
    s_wdata = val_r;
    s_raddr = k_r;
    unique case (state_r)
      ST_IDLE: begin
        s_raddr = count_r[ADDR_W-1:0] - 6'd1;
      end
      ST_INS: begin
        s_we    = shift_c;
        s_wdata = s_rdata;
        s_raddr = j_r - 6'd2;
      end
      ST_PLACE: begin
        s_we = 1'b1;
      end
      ST_SADR: begin
        s_raddr = mid_c;
      end
      default: begin
        s_raddr = k_r;
      end
    endcase
  end

  rcs_ram #(.DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (k_r),
    .rdata (e_rdata)
  );

  rcs_ram #(.DEPTH(MAX_ITEMS)) u_sort_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      j_r     <= '0;
      k_r     <= '0;
      which_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            val_r  <= in_value;
            last_r <= in_last;
            k_r    <= '0;
            j_r    <= count_r[ADDR_W-1:0];
            if (room) begin
              // empty store goes straight to placement
              state_r <= (count_r == '0) ? ST_PLACE : ST_INS;
            end else begin
              ovf_r   <= 1'b1;
              state_r <= in_last ? ST_RD : ST_IDLE;
            end
          end
        end
        ST_INS: begin
          if (shift_c) begin
            j_r <= j_r - 6'd1;
            if (j_r == 6'd1) begin
              state_r <= ST_PLACE;
            end
          end else begin
            state_r <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          count_r <= count_r + 7'd1;
          state_r <= last_r ? ST_RD : ST_IDLE;
        end
        ST_RD: begin
          state_r <= ST_LD;
        end
        ST_LD: begin
          sval_r   <= s_rdata;
          target_r <= e_rdata;
          lo_r     <= '0;
          hi_r     <= hi_init;
          which_r  <= 1'b0;
          state_r  <= ST_SADR;
        end
        ST_SADR: begin
          if (probe_ok) begin
            mid_r   <= mid_c;
            state_r <= ST_SCMP;
          end else begin
            // not found: tag zero
            if (!which_r) begin
              rank_r   <= '0;
              target_r <= sval_r;
              which_r  <= 1'b1;
              lo_r     <= '0;
              hi_r     <= hi_init;
            end else begin
              srank_r <= '0;
              state_r <= ST_WAIT;
            end
          end
        end
        ST_SCMP: begin
          if (s_rdata == target_r) begin
            if (!which_r) begin
              rank_r   <= mid_r;
              target_r <= sval_r;
              which_r  <= 1'b1;
              lo_r     <= '0;
              hi_r     <= hi_init;
              state_r  <= ST_SADR;
            end else begin
              srank_r <= mid_r;
              state_r <= ST_WAIT;
            end
          end else begin
            if (s_rdata < target_r) begin
              lo_r <= $signed({2'b00, mid_r}) + 8'sd1;
            end else begin
              hi_r <= $signed({2'b00, mid_r}) - 8'sd1;
            end
            state_r <= ST_SADR;
          end
        end
        ST_WAIT: begin
          if (out_xfer) begin
            if (out_done_res) begin
              count_r <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + 6'd1;
              state_r <= ST_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `RCS_ASSERT(a_no_overlap, !(in_ready && out_valid), "load and result phases overlap")
  `RCS_ASSERT(a_count_cap, count_r <= MAX_CNT, "element count beyond capacity")
  `RCS_ASSERT(a_end_clears, out_xfer && out_done_res |=> count_r == '0 && !ovf_r, "set not cleared")
  `RCS_ASSERT(a_walk_index, state_r == ST_INS |-> j_r != '0, "insertion walk below slot zero")
endmodule

### rtl/rcs_ram.sv
// synchronous memory, one write and one read port, registered read data
// depends on rcs_pkg
module rcs_ram #(
  parameter int DEPTH = 64
) (
  input  logic          clk,
  input  logic          we,
  input  rcs_pkg::addr_t waddr,
  input  rcs_pkg::data_t wdata,
  input  rcs_pkg::addr_t raddr,
  output rcs_pkg::data_t rdata
);
  import rcs_pkg::*;

  data_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### test/rank_compress_sort_core_test.sv
// self-checking testbench for rank_compress_sort_core: loads random and directed sets and
// checks every rank, sorted value, sorted tag, overflow flag and done marker against a predictor
// depends on rcs_pkg and the rtl of the block
module rank_compress_sort_core_test;
  import rcs_pkg::*;

  localparam int CAPACITY    = MAX_ITEMS_DEF;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF    = 1500;

  // one expected result of a set
  typedef struct {
    addr_t position;
    addr_t rank;
    data_t sorted_value;
    addr_t sorted_rank;
    logic  dropped;
    logic  done_res;
  } rank_result_t;

  // predictor of the block plus the queue of results still to come
  class rank_scoreboard;
    data_t        arrival_q[$];
    data_t        ordered_q[$];
    bit           overflow;
    rank_result_t pending_q[$];
    int           errors;
    int           results_seen;
    int           sets_closed;
    int           overflow_sets;

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("mismatch at %0t: %s", $time, what);
    endtask

    // binary search over the sorted copy, midpoint rounded down
    function automatic addr_t search_tag(data_t v);
      int lo = 0;
      int hi = ordered_q.size() - 1;
      int mid;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (ordered_q[mid] == v) return addr_t'(mid);
        if (ordered_q[mid] < v) lo = mid + 1;
        else hi = mid - 1;
      end
      return '0;
    endfunction

    function void note_input(data_t v, logic last);
      int j;
      int n;
      addr_t tags[$];
      addr_t tags_sorted[$];
      rank_result_t r;
      if (arrival_q.size() < CAPACITY) begin
        arrival_q.push_back(v);
        j = ordered_q.size();
        while (j > 0 && v < ordered_q[j-1]) j--;
        ordered_q.insert(j, v);
      end else begin
        overflow = 1'b1;
      end
      if (!last) return;
      n = arrival_q.size();
      foreach (arrival_q[k]) tags.push_back(search_tag(arrival_q[k]));
      tags_sorted = tags;
      tags_sorted.sort();
      for (int k = 0; k < n; k++) begin
        r.position     = addr_t'(k);
        r.rank         = tags[k];
        r.sorted_value = ordered_q[k];
        r.sorted_rank  = tags_sorted[k];
        r.dropped      = overflow;
        r.done_res     = (k == n - 1);
        pending_q.push_back(r);
      end
      sets_closed++;
      if (overflow) overflow_sets++;
      arrival_q.delete();
      ordered_q.delete();
      overflow = 1'b0;
    endfunction

    task check_result(rank_result_t got);
      rank_result_t exp;
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result at position %0d", got.position));
        return;
      end
      exp = pending_q.pop_front();
      if (got.position !== exp.position)
        report_mismatch($sformatf("position %0d, want %0d", got.position, exp.position));
      if (got.rank !== exp.rank)
        report_mismatch($sformatf("pos %0d rank %0d, want %0d", exp.position, got.rank, exp.rank));
      if (got.sorted_value !== exp.sorted_value)
        report_mismatch($sformatf("pos %0d sorted value %0d, want %0d", exp.position,
                                  got.sorted_value, exp.sorted_value));
      if (got.sorted_rank !== exp.sorted_rank)
        report_mismatch($sformatf("pos %0d sorted tag %0d, want %0d", exp.position,
                                  got.sorted_rank, exp.sorted_rank));
      if (got.dropped !== exp.dropped)
        report_mismatch($sformatf("pos %0d dropped %0b, want %0b", exp.position,
                                  got.dropped, exp.dropped));
      if (got.done_res !== exp.done_res)
        report_mismatch($sformatf("pos %0d done %0b, want %0b", exp.position,
                                  got.done_res, exp.done_res));
    endtask
  endclass

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  data_t in_value  = '0;
  logic  in_last   = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  addr_t out_position;
  addr_t out_rank;
  data_t out_sorted_value;
  addr_t out_sorted_rank;
  logic  out_dropped;
  logic  out_done_res;

  rank_scoreboard rank_sb = new();
  int  items_sent;
  int  cycle_count;
  bit  sender_done;

  rank_compress_sort_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_rank         (out_rank),
    .out_sorted_value (out_sorted_value),
    .out_sorted_rank  (out_sorted_rank),
    .out_dropped      (out_dropped),
    .out_done_res     (out_done_res)
  );

  always #2 clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  // offer one element and hold it until the transfer; handshake is sampled on the
  // falling edge so the decision never races the block's own update at the rising edge
  task automatic send_element(data_t v, logic last);
    bit took;
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      if (took) rank_sb.note_input(v, last);
      @(posedge clk);
    end while (!took);
    items_sent++;
  endtask

  // bursts of back-to-back transfers broken by random idle gaps
  int burst_left;
  task automatic send_paced(data_t v, logic last);
    int gap;
    send_element(v, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // value mix: full range, a narrow band for plenty of duplicates, a wider band around zero, and the extremes
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return data_t'($urandom());
      4, 5, 6:    return data_t'(int'($urandom_range(0, 8)) - 4);
      7:          return 32'sh8000_0000 + data_t'($urandom_range(0, 2));
      8:          return 32'sh7fff_ffff - data_t'($urandom_range(0, 2));
      default:    return data_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_set(int size);
    for (int k = 0; k < size; k++) send_paced(pick_value(), k == size - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rank_sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int sets;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single minimum, the extremes together, duplicates, descending order, a repeated maximum
    send_element(32'sh8000_0000, 1'b1);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh8000_0000, 1'b0);
    send_element(32'sh0000_0000, 1'b0);
    send_element(-32'sd1, 1'b0);
    send_element(32'sd1, 1'b1);
    send_element(32'sd5, 1'b0);
    send_element(32'sd5, 1'b0);
    send_element(-32'sd3, 1'b0);
    send_element(32'sd5, 1'b0);
    send_element(32'sd5, 1'b1);
    for (int k = 3; k >= 0; k--) send_element(data_t'(k), k == 0);
    send_element(32'sh7fff_ffff, 1'b0);
    send_element(32'sh7fff_ffff, 1'b1);

    // sender pause until every outstanding result has come back
    wait_drained();

    // random sets, mostly small; a full set and some over capacity sets in between
    sets = 0;
    while (items_sent < ITEM_TARGET) begin
      sets++;
      if (sets % 20 == 5) send_set(CAPACITY + $urandom_range(1, 6));
      else if (sets % 20 == 12) send_set(CAPACITY);
      else if ($urandom_range(0, 9) < 8) send_set($urandom_range(1, 10));
      else send_set($urandom_range(11, CAPACITY));
    end
    in_valid <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver: its own stall pattern, plus one long hold-off while the sender keeps offering
  initial begin
    int  phase_len;
    int  mode;
    bit  held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && rank_sb.results_seen >= 80) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
      end
      mode = $urandom_range(0, 2);
      phase_len = $urandom_range(10, 60);
      for (int c = 0; c < phase_len; c++) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          default: out_ready <= (c % 4 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // result monitor: a transfer sampled on the falling edge completes at the next rising edge
  always @(negedge clk) begin
    rank_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.position     = out_position;
      got.rank         = out_rank;
      got.sorted_value = out_sorted_value;
      got.sorted_rank  = out_sorted_rank;
      got.dropped      = out_dropped;
      got.done_res     = out_done_res;
      rank_sb.check_result(got);
    end
  end

  // end of run: drain, allow the block to settle, then the verdict
  initial begin
    wait (sender_done);
    while (rank_sb.pending_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (rank_sb.pending_q.size() != 0)
      rank_sb.report_mismatch($sformatf("%0d results never arrived", rank_sb.pending_q.size()));
    $display("run covered %0d elements in %0d sets (%0d over capacity), %0d results checked",
             items_sent, rank_sb.sets_closed, rank_sb.overflow_sets, rank_sb.results_seen);
    $display("mismatches counted: %0d", rank_sb.errors);
    if (rank_sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
